FILE: rtl/masked_byte_pattern_search_core_assert.svh
// Assertion macros used by the pattern search checker
`ifndef MASKED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its trigger
`define MBPS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pattern search check failed (same cycle)");

// Check a consequent in the cycle after its trigger
`define MBPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pattern search check failed (next cycle)");

`endif

FILE: rtl/mbps_pkg.sv
// Constants and register codes for the masked byte pattern search
package mbps_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int LEN_W       = 6;
	localparam int CNT_W       = 32;
	localparam int BYTE_W      = 8;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int PAT_REGS    = 4;
	localparam int MASK_W      = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_0 = 3'd0,
		REG_PATTERN_1 = 3'd1,
		REG_PATTERN_2 = 3'd2,
		REG_PATTERN_3 = 3'd3,
		REG_MASK      = 3'd4,
		REG_LENGTH    = 3'd5
	} cfg_reg_t;

endpackage

FILE: rtl/masked_byte_pattern_search_core.sv
// A result is registered: the byte that completes it enters stage one, then the result moves to the output register.
// One byte per cycle while the input is not stalled; all window positions are compared in parallel.
// The input stalls only while stage one holds a result and the output beat is not yet taken.
// Reset (arst_n low, asynchronous) clears the config registers, byte count, match flag and valids, not the window.
// Configuration writes complete in the cycle they are presented.
module masked_byte_pattern_search_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mbps_pkg::BYTE_W-1:0]          data_byte,
	input  logic                                 last_byte,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 found,
	output logic [mbps_pkg::CNT_W-1:0]           match_offset
);

	// configuration registers
	logic [mbps_pkg::CFG_DATA_W-1:0] pattern_q [mbps_pkg::PAT_REGS];
	logic [mbps_pkg::MASK_W-1:0]     mask_q;
	logic [mbps_pkg::LEN_W-1:0]      length_q;

	// search state
	logic [mbps_pkg::BYTE_W-1:0]     window_q [mbps_pkg::MAX_PATTERN];
	logic [mbps_pkg::CNT_W-1:0]      seen_q;
	logic                            reported_q;
	logic                            valid_s1;
	logic                            last_s1;

	// output register
	logic                            out_valid_q;
	logic                            found_q;
	logic [mbps_pkg::CNT_W-1:0]      offset_q;

	logic [mbps_pkg::PAT_REGS*mbps_pkg::CFG_DATA_W-1:0] pat_vec;
	logic [mbps_pkg::MAX_PATTERN-1:0] pos_ok;
	logic                            len_ok;
	logic                            hit;
	logic                            emit;
	logic                            out_free;
	logic                            s1_done;
	logic                            in_acc;
	logic                            restart;
	logic [mbps_pkg::CNT_W-1:0]      seen_base;

	assign cfg_ready = 1'b1;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mbps_pkg::PAT_REGS; i++) begin
				pattern_q[i] <= '0;
			end
			mask_q   <= '0;
			length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mbps_pkg::REG_PATTERN_0: pattern_q[0] <= cfg_data;
				mbps_pkg::REG_PATTERN_1: pattern_q[1] <= cfg_data;
				mbps_pkg::REG_PATTERN_2: pattern_q[2] <= cfg_data;
				mbps_pkg::REG_PATTERN_3: pattern_q[3] <= cfg_data;
				mbps_pkg::REG_MASK:      mask_q <= cfg_data[mbps_pkg::MASK_W-1:0];
				mbps_pkg::REG_LENGTH:    length_q <= cfg_data[mbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_vec = {pattern_q[3], pattern_q[2], pattern_q[1], pattern_q[0]};

	// compare each window slot against the pattern byte aligned to it
	always_comb begin
		logic [mbps_pkg::LEN_W-1:0] diff;
		logic [mbps_pkg::IDX_W-1:0] j;
		diff = '0;
		j    = '0;
		for (int k = 0; k < mbps_pkg::MAX_PATTERN; k++) begin
			diff = length_q - mbps_pkg::LEN_W'(k) - mbps_pkg::LEN_W'(1);
			j    = diff[mbps_pkg::IDX_W-1:0];
			if (mbps_pkg::LEN_W'(k) < length_q && mask_q[j]) begin
				pos_ok[k] = (window_q[k] == pat_vec[{j, 3'b000} +: mbps_pkg::BYTE_W]);
			end else begin
				pos_ok[k] = 1'b1;
			end
		end
	end

	assign len_ok = (length_q != '0)
		&& (length_q <= mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN))
		&& (seen_q >= {{(mbps_pkg::CNT_W-mbps_pkg::LEN_W){1'b0}}, length_q});
	assign hit    = len_ok && (&pos_ok);

	// decide on a result for the byte in stage one
	assign emit     = valid_s1 && !reported_q && (hit || last_s1);
	assign out_free = !out_valid_q || out_ready;
	assign s1_done  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || s1_done;
	assign in_acc   = in_valid && in_ready;
	assign restart  = s1_done && last_s1;

	assign seen_base = restart ? '0 : seen_q;

	// shift the window on each accepted beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int k = mbps_pkg::MAX_PATTERN - 1; k > 0; k--) begin
				window_q[k] <= window_q[k-1];
			end
			window_q[0] <= data_byte;
		end
	end

	// advance count, match flag and stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			reported_q <= 1'b0;
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			if (in_acc) begin
				seen_q <= (seen_base == '1) ? seen_base : seen_base + 1'b1;
			end else if (restart) begin
				seen_q <= '0;
			end
			if (restart) begin
				reported_q <= 1'b0;
			end else if (s1_done && emit) begin
				reported_q <= 1'b1;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
				last_s1  <= last_byte;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// hold a result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			found_q  <= hit;
			offset_q <= hit
				? seen_q - {{(mbps_pkg::CNT_W-mbps_pkg::LEN_W){1'b0}}, length_q}
				: '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

endmodule

FILE: rtl/mbps_checker.sv
// Port-level checks for the masked byte pattern search core
`include "masked_byte_pattern_search_core_assert.svh"

module mbps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            found,
	input logic [mbps_pkg::CNT_W-1:0]      match_offset
);

	// a miss result always carries a zero offset
	`MBPS_ASSERT_SAME(a_miss_offset_zero, out_valid && !found, match_offset == '0)

	// configuration beats are never stalled
	`MBPS_ASSERT_SAME(a_cfg_always_ready, cfg_valid, cfg_ready)

	// an empty output register lets the input through
	`MBPS_ASSERT_SAME(a_ready_when_drained, in_valid && !out_valid, in_ready)

	// hold a stalled result beat
	`MBPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(found) && $stable(match_offset))

endmodule

bind masked_byte_pattern_search_core mbps_checker u_mbps_checker (.*);
